// ----- design/run_length_sequence_store_macros.svh -----
// Assertion macros for the run-length sequence store.
// Used by the top level only; no other dependencies.
`ifndef RUN_LENGTH_SEQUENCE_STORE_MACROS_SVH
`define RUN_LENGTH_SEQUENCE_STORE_MACROS_SVH
// Check that a condition implies another in the same cycle.
`define RLS_ASSERT_IMPL(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that a condition implies another in the next cycle.
`define RLS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ----- design/rls_pkg.sv -----
// Shared types and codes for the run-length sequence store.
// No dependencies.
`default_nettype none
package rls_pkg;
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LENGTH_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INC,
        OP_DEC,
        OP_SHIFT
    } cell_op_e_t;

    // Per-operation command broadcast to every cell.
    typedef struct packed {
        cell_op_e_t op;
        logic [7:0] letter;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- design/run_length_sequence_store.sv -----
// Run-length sequence store: a row of run cells, each holding one run's letter and
// count and its running end position. A beat is latched on acceptance; in the exec state
// the cells search and update and the result is registered. The result is held
// until taken and the next beat is accepted in the cycle after that, so no new beat
// is taken before the last result is taken. The position search
// compares every cell's registered end position at once, so its cost is one compare
// per cell plus a priority pick over MAX_RUNS cells. No clearing pass is needed.
// Depends on rls_pkg, rls_cell and run_length_sequence_store_macros.svh.
`default_nettype none
`include "run_length_sequence_store_macros.svh"
module run_length_sequence_store
    import rls_pkg::*;
#(
    parameter int MAX_RUNS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // action[1:0], value[9:2], position[25:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // status[1:0], letter[9:2], total_length[25:10],
                                       // run_total[32:26]
);
    localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RW = $clog2(MAX_RUNS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    state_t state_reg, state_next;
    logic [1:0]          act_reg;
    logic [7:0]          val_reg;
    logic [15:0]         pos_reg;
    logic [RW-1:0]       used_reg, used_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [1:0]          st_reg, st_next;
    logic [7:0]          let_reg, let_next;

    logic [7:0]            c_letter [MAX_RUNS+2];
    logic [COUNT_BITS-1:0] c_count  [MAX_RUNS+2];
    logic [LEN_BITS-1:0]   c_end    [MAX_RUNS+2];
    logic [LEN_BITS-1:0]   new_end;
    logic [MAX_RUNS-1:0]   hit, sel, after, load_new, merge_add;
    logic [IW-1:0]         k;
    logic                  shift2, do_exec;
    cell_cmd_t             cmd;

    assign c_letter[MAX_RUNS]   = '0;
    assign c_count[MAX_RUNS]    = '0;
    assign c_end[MAX_RUNS]      = '0;
    assign c_letter[MAX_RUNS+1] = '0;
    assign c_count[MAX_RUNS+1]  = '0;
    assign c_end[MAX_RUNS+1]    = '0;

    assign new_end = len_reg + LEN_BITS'(1);

    // Flag used cells whose end position lies past the requested position.
    always_comb begin
        for (int i = 0; i < MAX_RUNS; i++) begin
            hit[i] = (RW'(i) < used_reg) && (c_end[i] > pos_reg);
        end
    end

    // Pick the first hit cell.
    always_comb begin
        k = '0;
        for (int i = MAX_RUNS - 1; i >= 0; i--) begin
            if (hit[i]) k = IW'(i);
        end
    end

    // Decide the operation of this beat.
    always_comb begin
        logic [IW-1:0] last;
        logic          same, room, merge;
        last      = IW'(used_reg - RW'(1));
        cmd.op    = OP_HOLD;
        cmd.letter = val_reg;
        sel       = '0;
        after     = '0;
        load_new  = '0;
        merge_add = '0;
        shift2    = 1'b0;
        used_next = used_reg;
        len_next  = len_reg;
        st_next   = ST_OK;
        let_next  = '0;
        same  = (used_reg != '0) && (c_letter[last] == val_reg) &&
                (c_count[last] < COUNT_LIMIT);
        room  = used_reg < RW'(MAX_RUNS);
        merge = 1'b0;
        if (do_exec) begin
            case (act_reg)
                ACT_APPEND: begin
                    if (val_reg != 8'd0) begin
                        if (len_reg >= LENGTH_LIMIT) begin
                            st_next = ST_FULL;
                        end else if (same) begin
                            cmd.op    = OP_INC;
                            sel[last] = 1'b1;
                            len_next  = len_reg + 1'b1;
                        end else if (!room) begin
                            st_next = ST_FULL;
                        end else begin
                            load_new[IW'(used_reg)] = 1'b1;
                            used_next = used_reg + RW'(1);
                            len_next  = len_reg + 1'b1;
                        end
                    end
                end
                ACT_GET, ACT_REMOVE: begin
                    if (LEN_BITS'(pos_reg) >= len_reg) begin
                        st_next = ST_RANGE;
                    end else if (act_reg == ACT_GET) begin
                        let_next = c_letter[k];
                    end else begin
                        len_next = len_reg - 1'b1;
                        sel[k]   = 1'b1;
                        // Every later run ends one position earlier.
                        for (int i = 0; i < MAX_RUNS; i++) begin
                            after[i] = IW'(i) > k;
                        end
                        if (c_count[k] > COUNT_BITS'(1)) begin
                            cmd.op = OP_DEC;
                        end else begin
                            cmd.op    = OP_SHIFT;
                            used_next = used_reg - RW'(1);
                            merge = (k != '0) && (RW'(k) + RW'(1) < used_reg) &&
                                    (c_letter[k-1] == c_letter[k+1]) &&
                                    ({1'b0, c_count[k-1]} + {1'b0, c_count[k+1]}
                                        <= {1'b0, COUNT_LIMIT});
                            if (merge) begin
                                shift2 = 1'b1;
                                merge_add[k-1] = 1'b1;
                                used_next = used_reg - RW'(2);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Merge sums the left neighbor with the run two ahead of it.
    genvar g;
    generate
        for (g = 0; g < MAX_RUNS; g++) begin : g_cell
            rls_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .sel       (sel[g]),
                .after     (after[g]),
                .load_new  (load_new[g]),
                .merge_add (merge_add[g]),
                .new_end   (new_end),
                .nb_letter (c_letter[g+1]),
                .nb_count  (merge_add[g] ? c_count[g+2] : c_count[g+1]),
                .nb_end    (c_end[g+1]),
                .nb2_letter(c_letter[g+2]),
                .nb2_count (c_count[g+2]),
                .nb2_end   (c_end[g+2]),
                .shift2    (shift2),
                .letter    (c_letter[g]),
                .count     (c_count[g]),
                .run_end   (c_end[g])
            );
        end
    endgenerate

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
        do_exec  = (state_reg == S_EXEC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            len_reg   <= len_next;
        end
    end

    // Latch the beat and the result.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= s_tdata[1:0];
            val_reg <= s_tdata[9:2];
            pos_reg <= s_tdata[25:10];
        end
        if (do_exec) begin
            st_reg  <= st_next;
            let_reg <= let_next;
        end
    end

    assign m_tdata = {7'd0, 7'(used_reg), len_reg, let_reg, st_reg};

    `RLS_ASSERT_IMPL(a_one_side, aclk, aresetn, 1'b1, !(s_tready && m_tvalid))
    `RLS_ASSERT_NEXT(a_exec_out, aclk, aresetn, do_exec, m_tvalid)
    `RLS_ASSERT_IMPL(a_used_max, aclk, aresetn, 1'b1, used_reg <= RW'(MAX_RUNS))
endmodule
`default_nettype wire

// ----- design/rls_cell.sv -----
// One run slot of the chain: letter, count and end position, with neighbor links.
// Depends on rls_pkg.
`default_nettype none
module rls_cell
    import rls_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire cell_cmd_t             cmd,
    input  wire logic                  sel,       // this slot is the target
    input  wire logic                  after,     // slot lies past the target
    input  wire logic                  load_new,  // open a new run here
    input  wire logic                  merge_add, // absorb count from two ahead
    input  wire logic [LEN_BITS-1:0]   new_end,   // end position of a new run
    input  wire logic [7:0]            nb_letter, // from slot i+1
    input  wire logic [COUNT_BITS-1:0] nb_count,
    input  wire logic [LEN_BITS-1:0]   nb_end,
    input  wire logic [7:0]            nb2_letter, // from slot i+2
    input  wire logic [COUNT_BITS-1:0] nb2_count,
    input  wire logic [LEN_BITS-1:0]   nb2_end,
    input  wire logic                  shift2,    // shift by two slots
    output logic [7:0]                 letter,
    output logic [COUNT_BITS-1:0]      count,
    output logic [LEN_BITS-1:0]        run_end
);
    logic [7:0]            letter_reg, letter_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [LEN_BITS-1:0]   end_reg, end_next;

    // Pick the slot update for this command.
    always_comb begin
        letter_next = letter_reg;
        count_next  = count_reg;
        end_next    = end_reg;
        if (load_new) begin
            letter_next = cmd.letter;
            count_next  = COUNT_BITS'(1);
            end_next    = new_end;
        end else if (merge_add) begin
            count_next = count_reg + nb_count;
            end_next   = nb2_end - LEN_BITS'(1);
        end else if (sel && cmd.op == OP_INC) begin
            count_next = count_reg + COUNT_BITS'(1);
            end_next   = end_reg + LEN_BITS'(1);
        end else if (sel && cmd.op == OP_DEC) begin
            count_next = count_reg - COUNT_BITS'(1);
            end_next   = end_reg - LEN_BITS'(1);
        end else if (after && cmd.op == OP_DEC) begin
            end_next = end_reg - LEN_BITS'(1);
        end else if ((after || sel) && cmd.op == OP_SHIFT) begin
            letter_next = shift2 ? nb2_letter : nb_letter;
            count_next  = shift2 ? nb2_count : nb_count;
            end_next    = (shift2 ? nb2_end : nb_end) - LEN_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        letter_reg <= letter_next;
        count_reg  <= count_next;
        end_reg    <= end_next;
    end

    assign letter  = letter_reg;
    assign count   = count_reg;
    assign run_end = end_reg;
endmodule
`default_nettype wire

// ----- verif/run_length_sequence_store_checker.sv -----
// Checker for the run-length sequence store: watches both stream channels,
// predicts each result from a private copy of the run table, and counts mismatches.
// Depends on rls_pkg.
`default_nettype none
module run_length_sequence_store_checker
    import rls_pkg::*;
#(
    parameter int MAX_RUNS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    output int               fail_count,
    output int               pending_results,
    output int               seen_results,
    output int               full_seen,
    output int               range_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]  run_total;
        logic [15:0] total_length;
        logic [7:0]  letter;
        logic [1:0]  status;
    } store_result_t;

    localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

    logic [7:0]    shadow_letter [MAX_RUNS];
    longint        shadow_count  [MAX_RUNS];
    int            shadow_runs;
    int            shadow_len;
    store_result_t expected_results [$];

    initial begin
        fail_count = 0;
        seen_results = 0;
        full_seen = 0;
        range_seen = 0;
        shadow_runs = 0;
        shadow_len = 0;
    end

    assign pending_results = expected_results.size();

    // Remove run k from the shadow table and close the gap.
    function automatic void squeeze_run(int k);
        for (int i = k; i + 1 < shadow_runs; i++) begin
            shadow_letter[i] = shadow_letter[i + 1];
            shadow_count[i]  = shadow_count[i + 1];
        end
        shadow_runs--;
    endfunction

    // Apply one command to the shadow table and return the expected result.
    function automatic store_result_t apply_command(logic [1:0] act, logic [7:0] val,
                                                    logic [15:0] pos);
        store_result_t r;
        longint        run_end;
        int            k;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_APPEND) begin
            if (val != 8'd0) begin
                if (shadow_len >= int'(LENGTH_LIMIT)) begin
                    r.status = ST_FULL;
                end else if (shadow_runs > 0 && shadow_letter[shadow_runs - 1] == val
                             && shadow_count[shadow_runs - 1] < COUNT_MAX) begin
                    shadow_count[shadow_runs - 1]++;
                    shadow_len++;
                end else if (shadow_runs >= MAX_RUNS) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_letter[shadow_runs] = val;
                    shadow_count[shadow_runs] = 1;
                    shadow_runs++;
                    shadow_len++;
                end
            end
        end else if (act == ACT_GET || act == ACT_REMOVE) begin
            if (int'(pos) >= shadow_len) begin
                r.status = ST_RANGE;
            end else begin
                // Locate the run that covers the position
                run_end = 0;
                k = shadow_runs - 1;
                for (int i = 0; i < shadow_runs; i++) begin
                    run_end += shadow_count[i];
                    if (run_end > pos) begin
                        k = i;
                        break;
                    end
                end
                if (act == ACT_GET) begin
                    r.letter = shadow_letter[k];
                end else begin
                    shadow_len--;
                    if (shadow_count[k] > 1) begin
                        shadow_count[k]--;
                    end else begin
                        squeeze_run(k);
                        // Merge equal neighbors when the sum still fits
                        if (k > 0 && k < shadow_runs
                            && shadow_letter[k - 1] == shadow_letter[k]
                            && shadow_count[k - 1] + shadow_count[k] <= COUNT_MAX) begin
                            shadow_count[k - 1] += shadow_count[k];
                            squeeze_run(k);
                        end
                    end
                end
            end
        end
        r.total_length = shadow_len[15:0];
        r.run_total = shadow_runs[6:0];
        return r;
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge aclk) begin
        store_result_t want;
        store_result_t got;
        if (aresetn && s_tvalid && s_tready) begin
            want = apply_command(s_tdata[1:0], s_tdata[9:2], s_tdata[25:10]);
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_RANGE) range_seen++;
            expected_results.push_back(want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[32:0];
            seen_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    fail_count++;
                end
                if (got.letter !== want.letter) begin
                    $display("%0t: letter expected %h actual %h", $time,
                             want.letter, got.letter);
                    fail_count++;
                end
                if (got.total_length !== want.total_length) begin
                    $display("%0t: total_length expected %0d actual %0d", $time,
                             want.total_length, got.total_length);
                    fail_count++;
                end
                if (got.run_total !== want.run_total) begin
                    $display("%0t: run_total expected %0d actual %0d", $time,
                             want.run_total, got.run_total);
                    fail_count++;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- verif/run_length_sequence_store_test.sv -----
// Testbench top for the run-length sequence store: drives commands and result
// backpressure, and gives the verdict. Depends on rls_pkg, the block and the checker.
`default_nettype none
module run_length_sequence_store_test
    import rls_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUNS   = 64;
    localparam int COUNT_BITS = 16;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // action[1:0], value[9:2], position[25:10]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status[1:0], letter[9:2], total_length[25:10], run_total[32:26]

    int fail_count, pending_results, seen_results, full_seen, range_seen;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int model_len;
    int sent_items;

    run_length_sequence_store #(.MAX_RUNS(MAX_RUNS), .COUNT_BITS(COUNT_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    run_length_sequence_store_checker #(.MAX_RUNS(MAX_RUNS), .COUNT_BITS(COUNT_BITS)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_results(pending_results),
        .seen_results(seen_results), .full_seen(full_seen), .range_seen(range_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Result backpressure: random stall, or a long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off counted in cycles in its own process
    task automatic stall_results(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge aclk);
        hold_off = 1'b0;
    endtask

    // Offer one command beat, with a random gap, and wait for acceptance
    task automatic send_command(logic [1:0] act, logic [7:0] val, logic [15:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pos, val, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        // Rough length tracking to keep positions mostly in range
        if (act == ACT_APPEND && val != 0 && model_len < 65535) model_len++;
        if (act == ACT_REMOVE && pos < model_len) model_len--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Random mix: runs of letters, gets and removes mostly in range, some noise
    task automatic random_phase(int count);
        int pick;
        logic [7:0] letter;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                letter = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(65, 68));
                repeat ($urandom_range(1, 4)) send_command(ACT_APPEND, letter, 16'($urandom));
            end else if (pick < 65) begin
                send_command(ACT_GET, 8'($urandom),
                    model_len > 0 ? 16'($urandom_range(model_len - 1)) : 16'd0);
            end else if (pick < 92) begin
                send_command(ACT_REMOVE, 8'($urandom),
                    model_len > 0 ? 16'($urandom_range(model_len - 1)) : 16'd0);
            end else begin
                send_command(2'($urandom), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        model_len = 0;
        sent_items = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, zero letter, extremes, spare action, merges
        send_command(ACT_GET, 8'hFF, 16'd0);
        send_command(ACT_REMOVE, 8'h00, 16'hFFFF);
        send_command(ACT_APPEND, 8'h00, 16'd0);
        send_command(ACT_APPEND, 8'hFF, 16'hFFFF);
        send_command(ACT_APPEND, 8'h01, 16'd0);
        send_command(ACT_APPEND, 8'hFF, 16'd0);
        send_command(ACT_APPEND, 8'hFF, 16'd0);
        send_command(ACT_GET, 8'd0, 16'd0);
        send_command(ACT_GET, 8'd0, 16'd3);
        send_command(ACT_GET, 8'd0, 16'd4);
        send_command(ACT_REMOVE, 8'd0, 16'd1);   // drop the single run, merge neighbors
        send_command(ACT_GET, 8'd0, 16'd2);
        send_command(ACT_SPARE, 8'hAA, 16'h5555);
        send_command(ACT_REMOVE, 8'd0, 16'd0);
        send_command(ACT_REMOVE, 8'd0, 16'd0);
        send_command(ACT_REMOVE, 8'd0, 16'd0);
        // Fill the run table to its limit, then one more new run
        for (int i = 0; i <= MAX_RUNS; i++)
            send_command(ACT_APPEND, 8'((i % 2) ? 8'h55 : 8'hAA), 16'd0);
        send_command(ACT_APPEND, 8'h55, 16'd0);   // extends the last run
        send_command(ACT_APPEND, 8'h33, 16'd0);   // table full
        // Empty the store again
        while (model_len > 0) send_command(ACT_REMOVE, 8'd0, 16'($urandom_range(model_len - 1)));

        // Long result hold-off while commands keep coming
        fork
            stall_results(300);
            random_phase(20);
        join
        drain();

        send_idle_pct = 26; recv_idle_pct = 71;
        random_phase(380);
        drain();
        send_idle_pct = 71; recv_idle_pct = 26;
        random_phase(380);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(320);
        drain();

        $display("Sent %0d command beats, checked %0d results (%0d full, %0d out of range).",
                 sent_items, seen_results, full_seen, range_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
